// File: sv/positional_sequence_store_unit_defines.svh
// Assertion macros shared by the checker of the positional sequence store.
`ifndef POSITIONAL_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PSS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/pss_pkg.sv
// Types and codes shared by the positional sequence store modules.
package pss_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_BACK  = 3'd4,
    CMD_REM_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_WRAP  = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     rd_sel;
    logic     tl_sel;
  } cell_ctl_t;

endpackage

// File: sv/positional_sequence_store_unit.sv
// Top level of the positional sequence store: command decode and cell chain.
//
// Input channel (in_valid_i / in_ready_o) carries one command beat: command_i,
// value_in_i and position_i. Output channel (out_valid_o / out_ready_i) carries
// result beats: status_o, value_out_o, length_o, head_value_o, tail_value_o
// and last_o.
// Inserts and removes shift the cell row in the cycle the beat is taken; the
// result is offered in the next cycle. With the receiver ready and no dump
// running, one command is taken every cycle.
// A dump of n elements gives n result beats, one per cycle while the receiver
// is ready, by rotating the first n cells towards the front; after the final
// beat the row is back in order, and no command is taken until that beat
// has been accepted. A failed command or a dump of an empty store gives a
// single beat. Reset empties the store and drops any pending result; cell
// contents are not cleared and are never shown before being written.
// When the receiver stalls, the result holds and no new command is taken.
module positional_sequence_store_unit #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [2:0]  command_i,
  input  logic signed [31:0] value_in_i,
  input  logic        [4:0]  position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [1:0]  status_o,
  output logic signed [31:0] value_out_o,
  output logic        [4:0]  length_o,
  output logic signed [31:0] head_value_o,
  output logic signed [31:0] tail_value_o,
  output logic               last_o
);
  import pss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int W  = ((CW > 5) ? CW : 5) + 1;

  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          dump_q, dump_d;
  logic          out_valid_q, out_valid_d;
  status_e       status_q, status_d;
  logic [31:0]   value_q, value_d;
  logic [31:0]   dhead_q, dhead_d;
  logic [31:0]   dtail_q, dtail_d;

  logic          in_fire, out_fire;
  logic [W-1:0]  cnt_w, pos_w, p_w;
  logic          ins_ok, rem_ok, dump_go, dump_end;
  status_e       st;
  logic [31:0]   rd_val, tl_val, head_val;

  logic [31:0]   cell_v[CAPACITY];
  logic [31:0]   rd_tap[CAPACITY];
  logic [31:0]   tl_tap[CAPACITY];

  assign in_ready_o = !dump_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  assign cnt_w = W'(count_q);
  assign pos_w = W'(position_i);

  // Decode the command against the current fill level
  always_comb begin
    st      = ST_OK;
    ins_ok  = 1'b0;
    rem_ok  = 1'b0;
    dump_go = 1'b0;
    p_w     = '0;
    case (cmd_e'(command_i))
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        if (cnt_w >= W'(CAPACITY)) begin
          st = ST_FULL;
        end else if (cmd_e'(command_i) == CMD_INS_FRONT) begin
          ins_ok = 1'b1;
        end else if (cmd_e'(command_i) == CMD_INS_BACK) begin
          ins_ok = 1'b1;
          p_w    = cnt_w;
        end else if (pos_w == '0 || pos_w > cnt_w + W'(1)) begin
          st = ST_RANGE;
        end else begin
          ins_ok = 1'b1;
          p_w    = pos_w - W'(1);
        end
      end
      CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_AT: begin
        if (cnt_w == '0) begin
          st = ST_EMPTY;
        end else if (cmd_e'(command_i) == CMD_REM_FRONT) begin
          rem_ok = 1'b1;
        end else if (cmd_e'(command_i) == CMD_REM_BACK) begin
          rem_ok = 1'b1;
          p_w    = cnt_w - W'(1);
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          st = ST_RANGE;
        end else begin
          rem_ok = 1'b1;
          p_w    = pos_w - W'(1);
        end
      end
      CMD_DUMP: begin
        if (cnt_w == '0) begin
          st = ST_EMPTY;
        end else begin
          dump_go = 1'b1;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // Build the cell row with its per-cell shift control
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [W-1:0] iw;
    logic [31:0]  left_v, right_v;
    cell_ctl_t    ctl;

    assign iw = W'(i);

    if (i == 0) begin : g_first
      assign left_v = 32'd0;
    end else begin : g_inner_l
      assign left_v = cell_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_v = 32'd0;
    end else begin : g_inner_r
      assign right_v = cell_v[i+1];
    end

    always_comb begin
      ctl.op     = OP_HOLD;
      ctl.rd_sel = (iw == p_w);
      ctl.tl_sel = (iw + W'(1) == cnt_w);
      if (dump_q) begin
        if (out_fire) begin
          if (iw + W'(1) < cnt_w) begin
            ctl.op = OP_RIGHT;
          end else if (iw + W'(1) == cnt_w) begin
            ctl.op = OP_WRAP;
          end
        end
      end else if (in_fire && ins_ok) begin
        if (iw == p_w) begin
          ctl.op = OP_LOAD;
        end else if (iw > p_w && iw <= cnt_w) begin
          ctl.op = OP_LEFT;
        end
      end else if (in_fire && rem_ok) begin
        if (iw >= p_w && iw + W'(1) < cnt_w) begin
          ctl.op = OP_RIGHT;
        end
      end
    end

    pss_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .load_i   (value_in_i),
      .left_i   (left_v),
      .right_i  (right_v),
      .wrap_i   (cell_v[0]),
      .value_o  (cell_v[i]),
      .rd_tap_o (rd_tap[i]),
      .tl_tap_o (tl_tap[i])
    );
  end

  // Gather the selected taps
  always_comb begin
    rd_val = 32'd0;
    tl_val = 32'd0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_val = rd_val | rd_tap[k];
      tl_val = tl_val | tl_tap[k];
    end
  end

  assign head_val = (count_q != '0) ? cell_v[0] : 32'd0;
  assign dump_end = dump_q && (W'(idx_q) + W'(1) == cnt_w);

  // Advance the fill level, the dump walk and the result register
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    dump_d      = dump_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    value_d     = value_q;
    dhead_d     = dhead_q;
    dtail_d     = dtail_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
      if (dump_q) begin
        if (dump_end) begin
          dump_d = 1'b0;
        end else begin
          out_valid_d = 1'b1;
          idx_d       = idx_q + IW'(1);
        end
      end
    end
    if (in_fire) begin
      out_valid_d = 1'b1;
      status_d    = st;
      value_d     = rem_ok ? rd_val : 32'd0;
      if (ins_ok) begin
        count_d = count_q + CW'(1);
      end else if (rem_ok) begin
        count_d = count_q - CW'(1);
      end
      if (dump_go) begin
        dump_d  = 1'b1;
        idx_d   = '0;
        dhead_d = head_val;
        dtail_d = tl_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      dump_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      dump_q      <= dump_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    value_q  <= value_d;
    dhead_q  <= dhead_d;
    dtail_q  <= dtail_d;
  end

  // Drive the result beat
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign value_out_o  = dump_q ? cell_v[0] : value_q;
  assign length_o     = cnt_w[4:0];
  assign head_value_o = dump_q ? dhead_q : head_val;
  assign tail_value_o = dump_q ? dtail_q : tl_val;
  assign last_o       = dump_q ? dump_end : 1'b1;

endmodule

// File: sv/pss_cell.sv
// One storage cell of the shifting chain, with its read taps.
module pss_cell (
  input  logic               clk_i,
  input  pss_pkg::cell_ctl_t ctl_i,
  input  logic        [31:0] load_i,
  input  logic        [31:0] left_i,
  input  logic        [31:0] right_i,
  input  logic        [31:0] wrap_i,
  output logic        [31:0] value_o,
  output logic        [31:0] rd_tap_o,
  output logic        [31:0] tl_tap_o
);
  import pss_pkg::*;

  logic [31:0] value_q, value_d;

  // Pick the next content from the neighbours, the front cell or the new value, or hold it
  always_comb begin
    case (ctl_i.op)
      OP_LOAD:  value_d = load_i;
      OP_LEFT:  value_d = left_i;
      OP_RIGHT: value_d = right_i;
      OP_WRAP:  value_d = wrap_i;
      default:  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // Drive the taps only when this cell is selected
  assign value_o  = value_q;
  assign rd_tap_o = ctl_i.rd_sel ? value_q : 32'd0;
  assign tl_tap_o = ctl_i.tl_sel ? value_q : 32'd0;

endmodule

// File: sv/pss_checker.sv
// Port-level checker of the positional sequence store, bound to the top level.
`include "positional_sequence_store_unit_defines.svh"

module pss_checker #(
  parameter int CAPACITY = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] value_out_o,
  input logic [4:0]  length_o,
  input logic [31:0] head_value_o,
  input logic [31:0] tail_value_o,
  input logic        last_o
);

  // Length never exceeds the capacity while it fits the field
  `PSS_ASSERT_NEVER(a_len_cap, clk_i, rst_ni, out_valid_o && CAPACITY < 32 && length_o > 5'(CAPACITY), "length above capacity")

  // An empty store reports zero head and tail
  `PSS_ASSERT(a_empty_zero, clk_i, rst_ni, out_valid_o && CAPACITY < 32 && length_o == 5'd0 |-> head_value_o == 32'd0 && tail_value_o == 32'd0, "nonzero head or tail on empty store")

  // No command is taken in the middle of a dump
  `PSS_ASSERT_NEVER(a_dump_block, clk_i, rst_ni, out_valid_o && !last_o && in_ready_o, "command taken during dump")

  // A stalled result beat holds
  `PSS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(value_out_o) && $stable(length_o) && $stable(head_value_o) && $stable(tail_value_o) && $stable(last_o), "stalled result changed")

endmodule

bind positional_sequence_store_unit pss_checker #(.CAPACITY(CAPACITY)) u_pss_checker (.*);
